/* hw/rtl/dletx_pkg.sv */
package dletx_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [7:0]  ESCAPE_RESET = 8'd16;
	localparam logic [7:0]  END_RESET    = 8'd3;
	localparam logic [15:0] MIN_LEN_RESET = 16'd4;

	typedef struct packed {
		logic [7:0]  escape_code;
		logic [7:0]  end_code;
		logic [15:0] min_frame_length;
	} cfg_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  payload_byte;
		logic        first_of_frame;
		logic        abandoned;
		logic        frame_end;
		logic        frame_long_enough;
		logic [15:0] frame_length;
	} res_t;

endpackage

/* hw/rtl/dletx_regs.sv */
module dletx_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dletx_pkg::ADDR_W-1:0]  paddr,
	input  logic [dletx_pkg::DATA_W-1:0]  pwdata,
	output logic [dletx_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output dletx_pkg::cfg_t               cfg
);
	import dletx_pkg::*;

	localparam logic [1:0] REG_ESCAPE  = 2'd0;
	localparam logic [1:0] REG_END     = 2'd1;
	localparam logic [1:0] REG_MIN_LEN = 2'd2;

	logic [7:0]  escape_code_q;
	logic [7:0]  end_code_q;
	logic [15:0] min_len_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_code_q <= ESCAPE_RESET;
			end_code_q    <= END_RESET;
			min_len_q     <= MIN_LEN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_ESCAPE:  escape_code_q <= pwdata[7:0];
				REG_END:     end_code_q    <= pwdata[7:0];
				REG_MIN_LEN: min_len_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ESCAPE:  prdata = {{(DATA_W-8){1'b0}}, escape_code_q};
			REG_END:     prdata = {{(DATA_W-8){1'b0}}, end_code_q};
			REG_MIN_LEN: prdata = {{(DATA_W-16){1'b0}}, min_len_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.escape_code      = escape_code_q;
	assign cfg.end_code         = end_code_q;
	assign cfg.min_frame_length = min_len_q;

endmodule

/* hw/rtl/dletx_core.sv */
module dletx_core #(
	parameter int LENGTH_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	input  dletx_pkg::cfg_t cfg,
	output logic            has_result,
	output dletx_pkg::res_t res
);
	import dletx_pkg::*;

	localparam logic [1:0] MODE_HUNT      = 2'd0;
	localparam logic [1:0] MODE_HUNT_ESC  = 2'd1;
	localparam logic [1:0] MODE_FRAME     = 2'd2;
	localparam logic [1:0] MODE_FRAME_ESC = 2'd3;
	localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

	logic [1:0]             mode_q;
	logic [1:0]             mode_d;
	logic [LENGTH_BITS-1:0] count_q;
	logic [LENGTH_BITS-1:0] count_d;
	logic [LENGTH_BITS-1:0] count_bump;
	logic [CMP_W-1:0]       count_ext;
	logic [CMP_W-1:0]       min_ext;
	logic [15:0]            len_sat;
	logic                   is_esc;
	logic                   is_end;

	assign is_esc     = (rx_byte == cfg.escape_code);
	assign is_end     = (rx_byte == cfg.end_code);
	assign count_bump = (&count_q) ? count_q : count_q + LENGTH_BITS'(1);
	assign count_ext  = CMP_W'(count_q);
	assign min_ext    = CMP_W'(cfg.min_frame_length);
	assign len_sat    = (count_ext > CMP_W'(16'hFFFF)) ? 16'hFFFF : count_ext[15:0];

	always_comb begin
		mode_d     = mode_q;
		count_d    = count_q;
		has_result = 1'b0;
		res        = '0;
		case (mode_q)
			MODE_HUNT: begin
				if (is_esc) mode_d = MODE_HUNT_ESC;
			end
			MODE_HUNT_ESC: begin
				if (is_esc || is_end) begin
					mode_d = MODE_HUNT;
				end else begin
					mode_d             = MODE_FRAME;
					count_d            = LENGTH_BITS'(1);
					has_result         = 1'b1;
					res.byte_valid     = 1'b1;
					res.payload_byte   = rx_byte;
					res.first_of_frame = 1'b1;
				end
			end
			MODE_FRAME: begin
				if (is_esc) begin
					mode_d = MODE_FRAME_ESC;
				end else begin
					count_d          = count_bump;
					has_result       = 1'b1;
					res.byte_valid   = 1'b1;
					res.payload_byte = rx_byte;
				end
			end
			MODE_FRAME_ESC: begin
				has_result = 1'b1;
				if (is_esc) begin
					// stuffed escape is payload
					mode_d           = MODE_FRAME;
					count_d          = count_bump;
					res.byte_valid   = 1'b1;
					res.payload_byte = rx_byte;
				end else if (is_end) begin
					mode_d                = MODE_HUNT;
					count_d               = '0;
					res.frame_end         = 1'b1;
					res.frame_long_enough = (count_ext >= min_ext);
					res.frame_length      = len_sat;
				end else begin
					// lone escape: drop open frame, this byte opens the next
					mode_d             = MODE_FRAME;
					count_d            = LENGTH_BITS'(1);
					res.abandoned      = 1'b1;
					res.byte_valid     = 1'b1;
					res.payload_byte   = rx_byte;
					res.first_of_frame = 1'b1;
				end
			end
			default: mode_d = MODE_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			count_q <= '0;
		end else if (step) begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

endmodule

/* hw/rtl/dle_etx_frame_deframer.sv */
// path: an accepted byte is held in stage 1, its result then in the result register
// throughput: one byte per cycle, while the result register is empty or being drained
// bytes that close nothing and emit nothing (hunting, skipped pairs, escapes) give no result
// reset clears the input and result stages, sets hunting with no escape pending,
// zeroes the byte count and loads the register defaults
module dle_etx_frame_deframer #(
	parameter int LENGTH_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dletx_pkg::ADDR_W-1:0]  paddr,
	input  logic [dletx_pkg::DATA_W-1:0]  pwdata,
	output logic [dletx_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          byte_valid,
	output logic [7:0]                    payload_byte,
	output logic                          first_of_frame,
	output logic                          abandoned,
	output logic                          frame_end,
	output logic                          frame_long_enough,
	output logic [15:0]                   frame_length
);
	import dletx_pkg::*;

	cfg_t       cfg;
	res_t       core_res;
	res_t       res_q;
	logic       core_has_res;
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       out_valid_q;
	logic       advance;
	logic       in_xfer;

	dletx_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// stage 1 moves on whenever the result slot is empty or being drained
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) rx_byte_s1 <= rx_byte;
	end

	dletx_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (rx_byte_s1),
		.cfg       (cfg),
		.has_result(core_has_res),
		.res       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= core_has_res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_has_res) res_q <= core_res;
	end

	assign out_valid         = out_valid_q;
	assign byte_valid        = res_q.byte_valid;
	assign payload_byte      = res_q.payload_byte;
	assign first_of_frame    = res_q.first_of_frame;
	assign abandoned         = res_q.abandoned;
	assign frame_end         = res_q.frame_end;
	assign frame_long_enough = res_q.frame_long_enough;
	assign frame_length      = res_q.frame_length;

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && core_has_res |=> out_valid_q)
		else $error("result from stage 1 not held in result register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");

	a_end_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.frame_end |-> !res_q.byte_valid && !res_q.first_of_frame
		&& res_q.frame_length != 16'd0)
		else $error("frame end result carries a payload byte or zero length");

endmodule
